[hdl/abhc_pkg.sv]
// abhc_pkg: shared types, fixed-point limits and the microcode program
// of the adc biquad high-pass cascade. no dependencies.
`timescale 1ns / 1ps

package abhc_pkg;

    // signal format q4.20 and coefficient field layout
    localparam int SIG_W        = 25;
    localparam int SIG_FRAC     = 20;
    localparam int COEF_W       = 20;
    localparam int COEF_REG_W   = 60;
    localparam int IN_LIMIT     = 1258291;
    localparam int STATE_LIMIT  = 8 << SIG_FRAC;
    localparam int STAGE_LIMIT  = 4 << SIG_FRAC;
    localparam int UNIT_ONE     = 1 << SIG_FRAC;
    localparam int X_SHIFT      = 12;
    localparam logic [23:0] GAIN_DEFAULT = 24'd2097152;

    localparam int STEP_W       = 4;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STAGE_COUNT = 3'd0,
        REG_COEF_FIRST  = 3'd1,
        REG_COEF_SECOND = 3'd2,
        REG_ADC_MID     = 3'd3,
        REG_ADC_GAIN    = 3'd4,
        REG_DAC_MID     = 3'd5,
        REG_DAC_SPAN    = 3'd6
    } reg_idx_t;

    // multiplier operand selects
    typedef enum logic [2:0] {
        MA_GAIN, MA_B0, MA_A1, MA_A2, MA_SPAN
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_DIFF, MB_Y, MB_O, MB_UNIT
    } mul_b_t;

    // writeback actions
    typedef enum logic [2:0] {
        WB_NONE, WB_X, WB_O, WB_Z1, WB_Z2, WB_EMIT
    } wb_t;

    // jump conditions
    typedef enum logic [1:0] {
        JC_NEXT, JC_NO_STAGES, JC_MORE, JC_END
    } jc_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic   mul_en;
        mul_a_t mul_a;
        mul_b_t mul_b;
        wb_t    wb;
        jc_t    jc;
        step_t  target;
    } ucode_t;

    typedef struct packed {
        logic   load;
        logic   fire;
        ucode_t uc;
    } ctrl_t;

    typedef struct packed {
        logic no_stages;
        logic more_sections;
    } stat_t;

    typedef struct packed {
        logic [COEF_REG_W-1:0] coef_first;
        logic [COEF_REG_W-1:0] coef_second;
        logic [11:0]           adc_mid;
        logic [23:0]           adc_gain;
        logic [11:0]           dac_mid;
        logic [11:0]           dac_span;
    } cfg_t;

    localparam step_t STEP_SECTION = 4'd2;
    localparam step_t STEP_DAC     = 4'd8;

    // control program, one word per step
    function automatic ucode_t ucode(input step_t step);
        ucode_t w;
        w = '{mul_en: 1'b0, mul_a: MA_GAIN, mul_b: MB_DIFF, wb: WB_NONE,
              jc: JC_END, target: '0};
        unique case (step)
            4'd0: w = '{1'b1, MA_GAIN, MB_DIFF, WB_NONE, JC_NEXT,      '0};
            4'd1: w = '{1'b0, MA_GAIN, MB_DIFF, WB_X,    JC_NO_STAGES, STEP_DAC};
            4'd2: w = '{1'b1, MA_B0,   MB_Y,    WB_NONE, JC_NEXT,      '0};
            4'd3: w = '{1'b0, MA_GAIN, MB_DIFF, WB_O,    JC_NEXT,      '0};
            4'd4: w = '{1'b1, MA_A1,   MB_O,    WB_NONE, JC_NEXT,      '0};
            4'd5: w = '{1'b0, MA_GAIN, MB_DIFF, WB_Z1,   JC_NEXT,      '0};
            4'd6: w = '{1'b1, MA_A2,   MB_O,    WB_NONE, JC_NEXT,      '0};
            4'd7: w = '{1'b0, MA_GAIN, MB_DIFF, WB_Z2,   JC_MORE,      STEP_SECTION};
            4'd8: w = '{1'b1, MA_SPAN, MB_UNIT, WB_NONE, JC_NEXT,      '0};
            4'd9: w = '{1'b0, MA_GAIN, MB_DIFF, WB_EMIT, JC_END,       '0};
            default: w = '{1'b0, MA_GAIN, MB_DIFF, WB_NONE, JC_END,    '0};
        endcase
        return w;
    endfunction

endpackage

[hdl/abhc_seq.sv]
// abhc_seq: step counter and program table of the cascade.
// takes status flags from abhc_dpath; uses abhc_pkg.
`timescale 1ns / 1ps

module abhc_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic            out_free,
    input  abhc_pkg::stat_t stat,
    output logic            busy,
    output abhc_pkg::ctrl_t ctrl
);

    logic                busy_reg, busy_next;
    abhc_pkg::step_t     step_reg, step_next;
    abhc_pkg::ucode_t    uc;
    logic                hold;
    logic                fire;

    assign uc   = abhc_pkg::ucode(step_reg);
    // the emit step waits for the output register to free up
    assign hold = (uc.wb == abhc_pkg::WB_EMIT) && !out_free;
    assign fire = busy_reg && !hold;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end else if (fire) begin
            unique case (uc.jc)
                abhc_pkg::JC_NEXT:      step_next = step_reg + 1'b1;
                abhc_pkg::JC_NO_STAGES: step_next = stat.no_stages ? uc.target
                                                                   : step_reg + 1'b1;
                abhc_pkg::JC_MORE:      step_next = stat.more_sections ? uc.target
                                                                       : step_reg + 1'b1;
                abhc_pkg::JC_END: begin
                    busy_next = 1'b0;
                    step_next = '0;
                end
                default: step_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign busy      = busy_reg;
    assign ctrl.load = start && !busy_reg;
    assign ctrl.fire = fire;
    assign ctrl.uc   = uc;

endmodule

[hdl/abhc_dpath.sv]
// abhc_dpath: shared multiplier, working registers, section delay states
// and dac code mapping. driven by abhc_seq; uses abhc_pkg.
`timescale 1ns / 1ps

module abhc_dpath #(
    parameter int SAMPLE_BITS    = 12,
    parameter int DAC_MAX_CODE   = 4095,
    parameter int MAX_SECTIONS   = 2,
    parameter int COEF_FRAC_BITS = 18
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  abhc_pkg::ctrl_t        ctrl,
    input  abhc_pkg::cfg_t         cfg,
    input  logic [1:0]             stage_cnt,
    input  logic [SAMPLE_BITS-1:0] adc_in,
    output abhc_pkg::stat_t        stat,
    output logic [SAMPLE_BITS-1:0] dac_code
);

    localparam int SIG_W   = abhc_pkg::SIG_W;
    localparam int A_W     = abhc_pkg::SIG_W;
    localparam int O_W     = (((41 - COEF_FRAC_BITS) > 23) ? (41 - COEF_FRAC_BITS) : 23) + 3;
    localparam int D_W     = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 1;
    localparam int PROD_W  = A_W + O_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int Z_N     = 2 * MAX_SECTIONS;
    localparam int ZI_W    = $clog2(Z_N);
    localparam int SEC_W   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int V_W     = 40;
    localparam int CODE_W  = 17;
    localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] LIM_IN    = ACC_W'(abhc_pkg::IN_LIMIT);
    localparam logic signed [ACC_W-1:0] LIM_STATE = ACC_W'(abhc_pkg::STATE_LIMIT);
    localparam logic signed [ACC_W-1:0] LIM_STAGE = ACC_W'(abhc_pkg::STAGE_LIMIT);
    localparam logic signed [SIG_W-1:0] LIM_UNIT  = SIG_W'(abhc_pkg::UNIT_ONE);
    localparam logic signed [V_W-1:0]   V_HALF    = V_W'(1) <<< (abhc_pkg::SIG_FRAC - 1);
    localparam logic signed [V_W-1:0]   V_LIMIT   = V_W'(DAC_MAX_CODE) <<< abhc_pkg::SIG_FRAC;

    function automatic logic signed [ACC_W-1:0] sat(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] lim
    );
        if (v < -lim) return -lim;
        if (v > lim)  return lim;
        return v;
    endfunction

    function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v);
        return (v + RND_HALF) >>> COEF_FRAC_BITS;
    endfunction

    logic [SAMPLE_BITS-1:0]     adc_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   p0_reg;
    logic signed [O_W-1:0]      o_reg;
    logic signed [SIG_W-1:0]    y_reg;
    logic [SEC_W-1:0]           sec_reg;
    logic signed [SIG_W-1:0]    z_reg [Z_N];

    logic [abhc_pkg::COEF_REG_W-1:0] coef;
    logic [23:0]                gain_eff;
    logic signed [D_W-1:0]      diff;
    logic signed [SIG_W-1:0]    y_unit;
    logic signed [A_W-1:0]      op_a;
    logic signed [O_W-1:0]      op_b;
    logic signed [PROD_W-1:0]   mul_w;
    logic [ZI_W-1:0]            z_addr, z1_addr, z2_addr;
    logic signed [SIG_W-1:0]    z_rd;
    logic signed [ACC_W-1:0]    prod_ext, p0_ext, z_ext;
    logic signed [ACC_W-1:0]    x_val, o_val, n1_val, n2_val, ys_val;
    logic signed [V_W-1:0]      v_w, v_rnd;
    logic [CODE_W-1:0]          code_sel;

    assign coef     = (sec_reg == '0) ? cfg.coef_first : cfg.coef_second;
    assign gain_eff = (cfg.adc_gain == '0) ? abhc_pkg::GAIN_DEFAULT : cfg.adc_gain;
    assign diff     = D_W'($signed({1'b0, adc_reg})) - D_W'($signed({1'b0, cfg.adc_mid}));
    assign y_unit   = (y_reg < -LIM_UNIT) ? -LIM_UNIT : ((y_reg > LIM_UNIT) ? LIM_UNIT : y_reg);

    always_comb begin
        case (ctrl.uc.mul_a)
            abhc_pkg::MA_GAIN: op_a = A_W'($signed({1'b0, gain_eff}));
            abhc_pkg::MA_B0:   op_a = A_W'($signed(coef[19:0]));
            abhc_pkg::MA_A1:   op_a = A_W'($signed(coef[39:20]));
            abhc_pkg::MA_A2:   op_a = A_W'($signed(coef[59:40]));
            abhc_pkg::MA_SPAN: op_a = A_W'($signed({1'b0, cfg.dac_span}));
            default:           op_a = '0;
        endcase
        case (ctrl.uc.mul_b)
            abhc_pkg::MB_DIFF: op_b = O_W'(diff);
            abhc_pkg::MB_Y:    op_b = O_W'(y_reg);
            abhc_pkg::MB_O:    op_b = o_reg;
            abhc_pkg::MB_UNIT: op_b = O_W'(y_unit);
            default:           op_b = '0;
        endcase
    end

    assign mul_w = op_a * op_b;

    // one read port: z2 while the z1 update runs, z1 otherwise
    assign z1_addr = ZI_W'({sec_reg, 1'b0});
    assign z2_addr = ZI_W'({sec_reg, 1'b1});
    assign z_addr  = (ctrl.uc.wb == abhc_pkg::WB_Z1) ? z2_addr : z1_addr;
    assign z_rd    = z_reg[z_addr];

    assign prod_ext = ACC_W'(prod_reg);
    assign p0_ext   = ACC_W'(p0_reg);
    assign z_ext    = ACC_W'(z_rd);

    assign x_val  = sat(prod_ext >>> abhc_pkg::X_SHIFT, LIM_IN);
    assign o_val  = rnd(prod_ext) + z_ext;
    // b1 = -2*b0, so b1*y is minus twice the saved b0*y product
    assign n1_val = sat(rnd(-(p0_ext <<< 1) - prod_ext) + z_ext, LIM_STATE);
    assign n2_val = sat(rnd(p0_ext - prod_ext), LIM_STATE);
    assign ys_val = sat(ACC_W'(o_reg), LIM_STAGE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < Z_N; i++) begin
                z_reg[i] <= '0;
            end
            sec_reg <= '0;
        end else if (ctrl.fire) begin
            case (ctrl.uc.wb)
                abhc_pkg::WB_X:  sec_reg <= '0;
                abhc_pkg::WB_Z1: z_reg[z1_addr] <= SIG_W'(n1_val);
                abhc_pkg::WB_Z2: begin
                    z_reg[z2_addr] <= SIG_W'(n2_val);
                    sec_reg        <= sec_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            adc_reg <= adc_in;
        end
        if (ctrl.fire) begin
            if (ctrl.uc.mul_en) begin
                prod_reg <= mul_w;
            end
            case (ctrl.uc.wb)
                abhc_pkg::WB_X: y_reg <= SIG_W'(x_val);
                abhc_pkg::WB_O: begin
                    p0_reg <= prod_reg;
                    o_reg  <= O_W'(o_val);
                end
                abhc_pkg::WB_Z2: y_reg <= SIG_W'(ys_val);
                default: ;
            endcase
        end
    end

    assign stat.no_stages     = (stage_cnt == 2'd0);
    assign stat.more_sections = ((3'(sec_reg) + 3'd1) < 3'(stage_cnt));

    // dac mapping from the span product
    always_comb begin
        v_w   = V_W'(prod_reg) + ($signed(V_W'(cfg.dac_mid)) <<< abhc_pkg::SIG_FRAC);
        v_rnd = v_w + V_HALF;
        if (v_w < 0) begin
            code_sel = '0;
        end else if (v_w > V_LIMIT) begin
            code_sel = CODE_W'(DAC_MAX_CODE);
        end else begin
            code_sel = v_rnd[abhc_pkg::SIG_FRAC +: CODE_W];
        end
    end

    assign dac_code = SAMPLE_BITS'(code_sel);

endmodule

[hdl/adc_biquad_highpass_cascade.sv]
// adc_biquad_highpass_cascade: adc code in, high-pass filtered dac code out.
// the microcode steps share a single multiplier, so a new sample is accepted
// only once the program for the last one has ended, and the emit step waits
// while the output register is still held. synchronous active-low reset
// loads register defaults and clears the delay states at once.
`timescale 1ns / 1ps

module adc_biquad_highpass_cascade #(
    parameter int SAMPLE_BITS    = 12,
    parameter int DAC_MAX_CODE   = 4095,
    parameter int MAX_SECTIONS   = 2,
    parameter int COEF_FRAC_BITS = 18
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,  // adc_sample
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,  // dac_sample
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [abhc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [abhc_pkg::COEF_REG_W-1:0]     cfg_data
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    logic [1:0]             stage_count_reg;
    abhc_pkg::cfg_t         cfg_reg;
    logic [1:0]             count_eff;
    logic                   busy;
    logic                   out_free;
    logic                   emit;
    abhc_pkg::ctrl_t        ctrl;
    abhc_pkg::stat_t        stat;
    logic [SAMPLE_BITS-1:0] dac_code;
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_count_reg     <= 2'd2;
            cfg_reg.coef_first  <= '0;
            cfg_reg.coef_second <= '0;
            cfg_reg.adc_mid     <= 12'd2048;
            cfg_reg.adc_gain    <= abhc_pkg::GAIN_DEFAULT;
            cfg_reg.dac_mid     <= 12'd2048;
            cfg_reg.dac_span    <= 12'd2048;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                abhc_pkg::REG_STAGE_COUNT: stage_count_reg     <= cfg_data[1:0];
                abhc_pkg::REG_COEF_FIRST:  cfg_reg.coef_first  <= cfg_data;
                abhc_pkg::REG_COEF_SECOND: cfg_reg.coef_second <= cfg_data;
                abhc_pkg::REG_ADC_MID:     cfg_reg.adc_mid     <= cfg_data[11:0];
                abhc_pkg::REG_ADC_GAIN:    cfg_reg.adc_gain    <= cfg_data[23:0];
                abhc_pkg::REG_DAC_MID:     cfg_reg.dac_mid     <= cfg_data[11:0];
                abhc_pkg::REG_DAC_SPAN:    cfg_reg.dac_span    <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign count_eff = (stage_count_reg > 2'(MAX_SECTIONS)) ? 2'(MAX_SECTIONS)
                                                            : stage_count_reg;

    assign s_axis_tready = !busy;
    assign out_free      = !m_valid_reg || m_axis_tready;

    abhc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_axis_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    abhc_dpath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .DAC_MAX_CODE   (DAC_MAX_CODE),
        .MAX_SECTIONS   (MAX_SECTIONS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .cfg       (cfg_reg),
        .stage_cnt (count_eff),
        .adc_in    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .stat      (stat),
        .dac_code  (dac_code)
    );

    assign emit = ctrl.fire && (ctrl.uc.wb == abhc_pkg::WB_EMIT);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= dac_code;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TDATA_W'(m_data_reg);

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_valid_reg || m_axis_tready))
        else $error("result emitted over an untaken item");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sequencer not busy after accepting an item");

    a_emit_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> busy)
        else $error("emit outside a running program");

endmodule

[test/abhc_filter_checker.sv]
// abhc_filter_checker: watches the sample, result and register channels of the
// adc biquad high-pass cascade, predicts each dac code and compares it in order.
// depends on abhc_pkg for the register indexes and fixed-point limits.
`timescale 1ns / 1ps

module abhc_filter_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // adc_sample
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // dac_sample
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [59:0] cfg_data,
    output int          outstanding,
    output int          mismatches
);

    localparam int     COEF_FRAC  = 18;
    localparam longint COEF_HALF  = 64'sd1 <<< (COEF_FRAC - 1);
    localparam longint CODE_HALF  = 64'sd1 <<< (abhc_pkg::SIG_FRAC - 1);
    localparam longint CODE_MAX   = 4095;
    localparam int     SECTIONS   = 2;

    abhc_pkg::cfg_t mirror;
    logic [1:0]  stage_count;
    longint      z_state [2*SECTIONS];
    logic [11:0] expected_dac [$];

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v < -lim) return -lim;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic longint coef_field(input logic [59:0] word, input int k);
        logic signed [19:0] f;
        f = word[20*k +: 20];
        return longint'(f);
    endfunction

    function automatic longint coef_round(input longint p);
        return (p + COEF_HALF) >>> COEF_FRAC;
    endfunction

    // runs one sample through the enabled sections and maps it to a dac code
    function automatic logic [11:0] filter_sample(input logic [11:0] adc);
        longint      gain, y, o, n1, n2, b0, a1, a2, v;
        logic [59:0] word;
        int          count, s;
        gain = (mirror.adc_gain == '0) ? longint'(abhc_pkg::GAIN_DEFAULT)
                                       : longint'(mirror.adc_gain);
        y = ((longint'(adc) - longint'(mirror.adc_mid)) * gain) >>> abhc_pkg::X_SHIFT;
        y = clamp_sym(y, abhc_pkg::IN_LIMIT);
        count = (stage_count > SECTIONS) ? SECTIONS : int'(stage_count);
        for (s = 0; s < count; s++) begin
            word = (s == 0) ? mirror.coef_first : mirror.coef_second;
            b0 = coef_field(word, 0);
            a1 = coef_field(word, 1);
            a2 = coef_field(word, 2);
            o  = coef_round(b0 * y) + z_state[2*s];
            // b1 = -2*b0 and b2 = b0; the unclamped stage output feeds back
            n1 = coef_round(-2 * b0 * y - a1 * o) + z_state[2*s+1];
            n2 = coef_round(b0 * y - a2 * o);
            z_state[2*s]   = clamp_sym(n1, abhc_pkg::STATE_LIMIT);
            z_state[2*s+1] = clamp_sym(n2, abhc_pkg::STATE_LIMIT);
            y = clamp_sym(o, abhc_pkg::STAGE_LIMIT);
        end
        y = clamp_sym(y, abhc_pkg::UNIT_ONE);
        v = y * longint'(mirror.dac_span) + (longint'(mirror.dac_mid) <<< abhc_pkg::SIG_FRAC);
        if (v < 0) return 12'd0;
        if (v > (CODE_MAX <<< abhc_pkg::SIG_FRAC)) return 12'(CODE_MAX);
        return 12'((v + CODE_HALF) >>> abhc_pkg::SIG_FRAC);
    endfunction

    task automatic report_mismatch(input string what, input logic [11:0] got,
                                   input logic [11:0] want);
        $display("%0t ns  dac mismatch (%s): got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        logic [11:0] want;
        if (!aresetn) begin
            stage_count = 2'd2;
            mirror = '{coef_first: '0, coef_second: '0, adc_mid: 12'd2048,
                       adc_gain: abhc_pkg::GAIN_DEFAULT, dac_mid: 12'd2048,
                       dac_span: 12'd2048};
            foreach (z_state[i]) z_state[i] = 0;
            expected_dac.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    abhc_pkg::REG_STAGE_COUNT: stage_count        = cfg_data[1:0];
                    abhc_pkg::REG_COEF_FIRST:  mirror.coef_first  = cfg_data;
                    abhc_pkg::REG_COEF_SECOND: mirror.coef_second = cfg_data;
                    abhc_pkg::REG_ADC_MID:     mirror.adc_mid     = cfg_data[11:0];
                    abhc_pkg::REG_ADC_GAIN:    mirror.adc_gain    = cfg_data[23:0];
                    abhc_pkg::REG_DAC_MID:     mirror.dac_mid     = cfg_data[11:0];
                    abhc_pkg::REG_DAC_SPAN:    mirror.dac_span    = cfg_data[11:0];
                    default: ;
                endcase
            end
            // results first, so a result in the cycle of a new sample cannot claim it
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_dac.size() == 0) begin
                    report_mismatch("no sample pending", m_axis_tdata[11:0], 12'd0);
                end else begin
                    want = expected_dac.pop_front();
                    if (m_axis_tdata[11:0] !== want)
                        report_mismatch("dac_sample", m_axis_tdata[11:0], want);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_dac.push_back(filter_sample(s_axis_tdata[11:0]));
        end
        outstanding <= expected_dac.size();
    end

endmodule

[test/tb_adc_biquad_highpass_cascade.sv]
// tb_adc_biquad_highpass_cascade: drives samples and register writes into the
// adc biquad high-pass cascade and gives the verdict; checking is in abhc_filter_checker.
// depends on abhc_pkg, adc_biquad_highpass_cascade and abhc_filter_checker.
`timescale 1ns / 1ps

module tb_adc_biquad_highpass_cascade;

    localparam logic [2:0] CFG_IDX_SPARE = 3'd7;
    localparam int DRAIN_PAD    = 20;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int MODE_SPLIT_A = 270;
    localparam int MODE_SPLIT_B = 540;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS  = 97;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // adc_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // dac_sample
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [59:0] cfg_data = '0;

    int outstanding;
    int mismatches;
    int items_sent = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always #5 aclk = ~aclk;

    adc_biquad_highpass_cascade u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    abhc_filter_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .outstanding   (outstanding),
        .mismatches    (mismatches)
    );

    // 0: sender idles lightly, receiver heavily; 1: the reverse; 2: no idling
    function automatic int idle_mode();
        if (items_sent < MODE_SPLIT_A) return 0;
        if (items_sent < MODE_SPLIT_B) return 1;
        return 2;
    endfunction

    function automatic int sender_gap();
        int gap, pct;
        gap = 0;
        pct = (idle_mode() == 0) ? 18 : (idle_mode() == 1) ? 67 : 0;
        while (gap < 40 && $urandom_range(0, 99) < pct) gap++;
        return gap;
    endfunction

    function automatic logic [59:0] pack_coef(input int b0, input int a1, input int a2);
        return {a2[19:0], a1[19:0], b0[19:0]};
    endfunction

    // stable high-pass section with unity gain at nyquist
    function automatic logic [59:0] draw_highpass_coef();
        int a2, a1m, b0;
        a2  = $urandom_range(78643, 249036);
        a1m = $urandom_range(131072, 262144 + a2 - 2000);
        b0  = (262144 + a1m + a2) / 4;
        return pack_coef(b0, -a1m, a2);
    endfunction

    // receiver: random stalls plus one long hold-off to back the block up
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_sent >= HOLD_AT) begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            case (idle_mode())
                0: m_axis_tready <= ($urandom_range(0, 99) >= 67);
                1: m_axis_tready <= ($urandom_range(0, 99) >= 18);
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** adc_biquad_highpass_cascade: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_sample(input logic [11:0] code);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, code};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_stream(input int n);
        int i, style, level, lo, hi;
        logic [11:0] code;
        style = 0;
        level = $urandom_range(0, 4095);
        lo = 0;
        hi = 4095;
        for (i = 0; i < n; i++) begin
            if (i % 32 == 0) begin
                style = $urandom_range(0, 3);
                lo = $urandom_range(0, 4095);
                hi = $urandom_range(0, 4095);
            end
            case (style)
                0: code = 12'($urandom_range(0, 4095));
                1: begin
                    // slow random walk, mostly removed by the high-pass
                    level = level + $urandom_range(0, 128) - 64;
                    if (level < 0) level = 0;
                    if (level > 4095) level = 4095;
                    code = 12'(level);
                end
                2: code = ((i / 8) % 2 == 1) ? 12'(hi) : 12'(lo);
                default: code = ($urandom_range(0, 1) == 1) ? 12'd4095 : 12'd0;
            endcase
            send_sample(code);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [59:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // registers change only once the filter has gone quiet
    task automatic load_settings(input logic [1:0] stages, input abhc_pkg::cfg_t c);
        wait_drained();
        write_reg(abhc_pkg::REG_STAGE_COUNT, 60'(stages));
        write_reg(abhc_pkg::REG_COEF_FIRST,  c.coef_first);
        write_reg(abhc_pkg::REG_COEF_SECOND, c.coef_second);
        write_reg(abhc_pkg::REG_ADC_MID,     60'(c.adc_mid));
        write_reg(abhc_pkg::REG_ADC_GAIN,    60'(c.adc_gain));
        write_reg(abhc_pkg::REG_DAC_MID,     60'(c.dac_mid));
        write_reg(abhc_pkg::REG_DAC_SPAN,    60'(c.dac_span));
        // unmapped index must be ignored
        write_reg(CFG_IDX_SPARE, 60'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int p;
        logic [1:0] stages;
        abhc_pkg::cfg_t c;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: zero coefficients, output sits at the dac midpoint
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2048);

        // no sections, gain zero falls back to the default, full dac span
        c = '{coef_first: '0, coef_second: '0, adc_mid: 12'd2048, adc_gain: 24'd0,
              dac_mid: 12'd2048, dac_span: 12'd4095};
        load_settings(2'd0, c);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2048);
        send_sample(12'd1);
        send_sample(12'd2047);

        // stage count three saturates to two; max gain drives the input clamp
        c = '{coef_first: pack_coef(237240, -471859, 214958),
              coef_second: pack_coef(214958, -419430, 178258),
              adc_mid: 12'd4095, adc_gain: 24'hFFFFFF, dac_mid: 12'd4095, dac_span: 12'd2048};
        load_settings(2'd3, c);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd2048);
        send_sample(12'd4095);

        // extreme coefficients push states into saturation, one section only
        c = '{coef_first: pack_coef(-524288, 524287, -524288),
              coef_second: pack_coef(524287, -524288, 524287),
              adc_mid: 12'd0, adc_gain: 24'hFFFFFF, dac_mid: 12'd0, dac_span: 12'd4095};
        load_settings(2'd1, c);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2048);

        // minimum gain and zero span
        c = '{coef_first: pack_coef(524287, -524288, 524287), coef_second: '0,
              adc_mid: 12'd2048, adc_gain: 24'd1, dac_mid: 12'd0, dac_span: 12'd0};
        load_settings(2'd2, c);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd1234);

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: stages = 2'd2;
                1: stages = 2'd1;
                2: stages = 2'($urandom_range(0, 3));
                default: stages = 2'd2;
            endcase
            c.coef_first  = (p % 3 == 2) ? 60'({$urandom, $urandom}) : draw_highpass_coef();
            c.coef_second = (p % 3 == 2) ? 60'({$urandom, $urandom}) : draw_highpass_coef();
            c.adc_mid  = (p == 5) ? 12'd0 : (p == 6) ? 12'd4095 : 12'($urandom_range(1500, 2600));
            c.adc_gain = (p == 3) ? 24'd0 : (p == 7) ? 24'($urandom) :
                         24'($urandom_range(1048576, 3145728));
            c.dac_mid  = (p == 4) ? 12'd0 : 12'($urandom_range(1024, 3072));
            c.dac_span = (p == 4) ? 12'd4095 : 12'($urandom_range(1000, 2047));
            load_settings(stages, c);
            send_stream(PHASE_ITEMS);
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("** adc_biquad_highpass_cascade: PASSED **");
        end else begin
            $display("** adc_biquad_highpass_cascade: FAILED **");
        end
        $finish;
    end

endmodule

[adc_biquad_highpass_cascade.f]
hdl/abhc_pkg.sv
hdl/abhc_seq.sv
hdl/abhc_dpath.sv
hdl/adc_biquad_highpass_cascade.sv
test/abhc_filter_checker.sv
test/tb_adc_biquad_highpass_cascade.sv
